/* rtl/sd_block_read_parser_assert.svh */
// ----------------------------------------------------------------------------
// sd block read parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SD_BLOCK_READ_PARSER_ASSERT_SVH
`define SD_BLOCK_READ_PARSER_ASSERT_SVH

// same-cycle implication
`define SBRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbrp assertion failed");

// next-cycle implication
`define SBRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbrp assertion failed");

`endif

/* rtl/sbrp_pkg.sv */
// ----------------------------------------------------------------------------
// sbrp_pkg
// types and constants of the sd card spi single block read parser
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam int unsigned PollLimit = 65536;
  localparam int unsigned PollW     = $clog2(PollLimit);
  localparam int unsigned BlockLenW = 13;
  localparam int unsigned IndexW    = 12;
  localparam int unsigned MaxBlock  = 4096;

  localparam logic [7:0] ByteIdle   = 8'hFF;
  localparam logic [7:0] ByteToken  = 8'hFE;
  localparam logic [7:0] ByteR1Ok   = 8'h00;
  localparam logic [7:0] R1BusyMask = 8'h80;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTimeout = 2'd1;
  localparam logic [1:0] StResp    = 2'd2;
  localparam logic [1:0] StData    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_R1    = 3'd1,
    PH_TOKEN = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC1  = 3'd4,
    PH_CRC2  = 3'd5,
    PH_TRAIL = 3'd6
  } phase_e;

  typedef struct packed {
    logic       start_read;
    logic [7:0] rx_byte;
  } sbrp_in_t;

  typedef struct packed {
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [IndexW-1:0] byte_index;
    logic              finished;
    logic [1:0]        read_status;
  } sbrp_out_t;

endpackage

/* rtl/sd_block_read_parser.sv */
// ----------------------------------------------------------------------------
// sd_block_read_parser
// parses bytes returned by an sd card in spi mode during a single block read
// output: each input transfer's result is registered, shown the cycle after
// throughput: one byte per cycle via one phase/counter update, unless stalled
// reset: idle phase, counters cleared, block length 512, no result held
// ----------------------------------------------------------------------------
`include "sd_block_read_parser_assert.svh"

module sd_block_read_parser
  import sbrp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [BlockLenW-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbrp_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbrp_out_t            out_data_o
);

  logic [BlockLenW-1:0] block_len_q;
  phase_e               phase_q, phase_d;
  logic [PollW-1:0]     poll_q, poll_d;
  logic [BlockLenW-1:0] data_q, data_d;
  logic [1:0]           pend_q, pend_d;
  logic                 out_valid_q;
  sbrp_out_t            out_data_q, res;

  logic                 in_fire;
  phase_e               cur_phase;
  logic [PollW-1:0]     cur_poll;
  logic [BlockLenW-1:0] cur_data;
  logic [1:0]           cur_pend;
  logic [BlockLenW-1:0] eff_len;
  logic [BlockLenW-1:0] data_inc;
  logic                 poll_expired;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a start byte restarts the parser before it is processed
  assign cur_phase = in_data_i.start_read ? PH_R1 : phase_q;
  assign cur_poll  = in_data_i.start_read ? '0 : poll_q;
  assign cur_data  = in_data_i.start_read ? '0 : data_q;
  assign cur_pend  = in_data_i.start_read ? StOk : pend_q;

  assign eff_len      = (block_len_q > BlockLenW'(MaxBlock)) ? BlockLenW'(MaxBlock)
                                                             : block_len_q;
  assign data_inc     = cur_data + BlockLenW'(1);
  assign poll_expired = (cur_poll == PollW'(PollLimit - 1));

  always_comb begin
    phase_d = phase_q;
    poll_d  = poll_q;
    data_d  = data_q;
    pend_d  = pend_q;
    if (in_fire) begin
      phase_d = cur_phase;
      poll_d  = cur_poll;
      data_d  = cur_data;
      pend_d  = cur_pend;
      case (cur_phase)
        PH_R1: begin
          poll_d = cur_poll + PollW'(1);
          if (poll_expired) begin
            pend_d  = StTimeout;
            phase_d = PH_TRAIL;
          end else if ((in_data_i.rx_byte & R1BusyMask) == ByteR1Ok) begin
            if (in_data_i.rx_byte == ByteR1Ok) begin
              poll_d  = '0;
              phase_d = PH_TOKEN;
            end else begin
              pend_d  = StResp;
              phase_d = PH_TRAIL;
            end
          end
        end
        PH_TOKEN: begin
          poll_d = cur_poll + PollW'(1);
          if (poll_expired) begin
            pend_d  = StTimeout;
            phase_d = PH_TRAIL;
          end else if (in_data_i.rx_byte != ByteIdle) begin
            if (in_data_i.rx_byte == ByteToken) begin
              data_d  = '0;
              phase_d = (eff_len == '0) ? PH_CRC1 : PH_DATA;
            end else begin
              pend_d  = StData;
              phase_d = PH_TRAIL;
            end
          end
        end
        PH_DATA: begin
          data_d = data_inc;
          if (data_inc >= eff_len) begin
            phase_d = PH_CRC1;
          end
        end
        PH_CRC1: begin
          phase_d = PH_CRC2;
        end
        PH_CRC2: begin
          pend_d  = StOk;
          phase_d = PH_TRAIL;
        end
        PH_TRAIL: begin
          phase_d = PH_IDLE;
          poll_d  = '0;
          data_d  = '0;
          pend_d  = StOk;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res = '0;
    case (cur_phase)
      PH_DATA: begin
        res.data_valid = 1'b1;
        res.data_byte  = in_data_i.rx_byte;
        res.byte_index = cur_data[IndexW-1:0];
      end
      PH_TRAIL: begin
        res.finished    = 1'b1;
        res.read_status = cur_pend;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_len_q <= BlockLenW'(512);
      phase_q     <= PH_IDLE;
      poll_q      <= '0;
      data_q      <= '0;
      pend_q      <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        block_len_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      poll_q  <= poll_d;
      data_q  <= data_d;
      pend_q  <= pend_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  `SBRP_ASSERT_NOW(a_hold_blocks_input, out_valid_q && !out_ready_i, !in_ready_o)
  `SBRP_ASSERT_NEXT(a_trail_finishes, in_fire && cur_phase == PH_TRAIL,
                    out_valid_o && out_data_o.finished)
  `SBRP_ASSERT_NEXT(a_data_byte_valid, in_fire && cur_phase == PH_DATA,
                    out_valid_o && out_data_o.data_valid && !out_data_o.finished)
  `SBRP_ASSERT_NEXT(a_trail_to_idle, in_fire && cur_phase == PH_TRAIL,
                    phase_q == PH_IDLE && poll_q == '0 && data_q == '0)

endmodule
